// ===== src/dirty_rectangle_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECTANGLE_TRACKER_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DRT_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (prop)) \
		else $error("dirty_rectangle_tracker check failed");
// condition must never be true outside reset
`define DRT_NEVER(lbl, ck, rst_n, cond) \
	`DRT_ASSERT(lbl, ck, rst_n, !(cond))
`else
`define DRT_ASSERT(lbl, ck, rst_n, prop)
`define DRT_NEVER(lbl, ck, rst_n, cond)
`endif
`endif

// ===== src/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker package
// Constants, codes and the stored rectangle type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package drt_pkg;
	localparam int SLOTS_DEFAULT = 32;
	localparam int RESULT_CAP    = 32;
	localparam int COORD_W       = 12;
	localparam int DIM_W         = 13;
	localparam int AREA_W        = 25;

	localparam logic [DIM_W-1:0] SCREEN_W_RST = 13'd480;
	localparam logic [DIM_W-1:0] SCREEN_H_RST = 13'd320;
	localparam logic [DIM_W-1:0] DIM_MAX      = 13'd4096;

	// request kinds
	localparam logic [1:0] KIND_INVALIDATE = 2'd0;
	localparam logic [1:0] KIND_JOIN       = 2'd1;
	localparam logic [1:0] KIND_EMIT       = 2'd2;
	localparam logic [1:0] KIND_CLEAR      = 2'd3;

	// result status codes
	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_COVERED  = 3'd1;
	localparam logic [2:0] ST_OUTSIDE  = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_JOINED   = 3'd4;
	localparam logic [2:0] ST_REGION   = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;
	localparam logic [2:0] ST_CLEARED  = 3'd7;

	// register indexes
	localparam logic CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} rect_t;
endpackage
`default_nettype wire

// ===== src/dirty_rectangle_tracker.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker
// Table of dirty screen rectangles with invalidate, join, emit and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Results appear for
// one cycle each with result_valid; the receiver cannot stall them, and last
// marks the final one. Invalidate walks the stored entries, join walks every
// pair of unjoined entries, and emit walks the stored entries; clear and a
// rectangle outside the screen answer straight from idle. The pace is set by
// the rectangle memory with one write port and a registered read port and
// the one shared area multiplier stepped by the sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "dirty_rectangle_tracker_defines.svh"
module dirty_rectangle_tracker #(
	parameter int REGION_SLOTS = drt_pkg::SLOTS_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [15:0]           x_left,
	input  wire logic signed [15:0]           y_top,
	input  wire logic signed [15:0]           x_right,
	input  wire logic signed [15:0]           y_bottom,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [drt_pkg::DIM_W-1:0]    cfg_data,
	output logic                              result_valid,
	output logic [2:0]                        status,
	output logic [4:0]                        region_index,
	output logic [drt_pkg::COORD_W-1:0]       out_x_left,
	output logic [drt_pkg::COORD_W-1:0]       out_y_top,
	output logic [drt_pkg::COORD_W-1:0]       out_x_right,
	output logic [drt_pkg::COORD_W-1:0]       out_y_bottom,
	output logic [drt_pkg::AREA_W-1:0]        pixel_count,
	output logic [4:0]                        merge_count,
	output logic [5:0]                        entries_used,
	output logic                              last
);
	import drt_pkg::*;

	localparam int IW = $clog2(REGION_SLOTS);
	localparam int CW = $clog2(REGION_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(REGION_SLOTS);

	typedef enum logic [3:0] {
		IDLE, V_RD, V_CMP, I_RD, I_LD, J_RD, J_F, J_B, J_CMP, E_SCAN, E_LD
	} state_t;

	state_t                state_q;
	logic [DIM_W-1:0]      scr_w_q, scr_h_q;
	logic [CW-1:0]         count_q, i_q, j_q;
	logic [REGION_SLOTS-1:0] marks_q;
	logic [5:0]            n_q;
	logic [4:0]            merges_q;
	rect_t                 c_q, a_q, b_q, rdata_q;
	logic [AREA_W-1:0]     area_a_q, area_f_q, area_b_q;

	rect_t                 mem_q [REGION_SLOTS];

	// clip the incoming rectangle to the screen
	logic [COORD_W-1:0]    wm1, hm1;
	logic signed [16:0]    sx1, sy1, sx2, sy2, cx1, cy1, cx2, cy2;
	logic                  clip_empty;
	rect_t                 clip_r, screen_r;

	assign wm1 = COORD_W'(scr_w_q - 13'd1);
	assign hm1 = COORD_W'(scr_h_q - 13'd1);
	assign sx1 = {x_left[15], x_left};
	assign sy1 = {y_top[15], y_top};
	assign sx2 = {x_right[15], x_right};
	assign sy2 = {y_bottom[15], y_bottom};

	always_comb begin
		cx1 = (sx1 > 17'sd0) ? sx1 : 17'sd0;
		cy1 = (sy1 > 17'sd0) ? sy1 : 17'sd0;
		cx2 = (sx2 < $signed({5'd0, wm1})) ? sx2 : $signed({5'd0, wm1});
		cy2 = (sy2 < $signed({5'd0, hm1})) ? sy2 : $signed({5'd0, hm1});
		clip_empty = (cx1 > cx2) || (cy1 > cy2);
		clip_r = '{x1: cx1[COORD_W-1:0], y1: cy1[COORD_W-1:0],
		           x2: cx2[COORD_W-1:0], y2: cy2[COORD_W-1:0]};
		screen_r = '{x1: '0, y1: '0, x2: wm1, y2: hm1};
	end

	// compare and bounding box against the memory read data
	logic  inside_c, overlap_af, merge_ok;
	rect_t bbox;

	always_comb begin
		inside_c = (c_q.x1 >= rdata_q.x1) && (c_q.y1 >= rdata_q.y1) &&
		           (c_q.x2 <= rdata_q.x2) && (c_q.y2 <= rdata_q.y2);
		overlap_af = !((a_q.x1 > rdata_q.x2) || (rdata_q.x1 > a_q.x2) ||
		               (a_q.y1 > rdata_q.y2) || (rdata_q.y1 > a_q.y2));
		bbox.x1 = (a_q.x1 < rdata_q.x1) ? a_q.x1 : rdata_q.x1;
		bbox.y1 = (a_q.y1 < rdata_q.y1) ? a_q.y1 : rdata_q.y1;
		bbox.x2 = (a_q.x2 > rdata_q.x2) ? a_q.x2 : rdata_q.x2;
		bbox.y2 = (a_q.y2 > rdata_q.y2) ? a_q.y2 : rdata_q.y2;
		merge_ok = {1'b0, area_b_q} < ({1'b0, area_a_q} + {1'b0, area_f_q});
	end

	// shared area multiplier
	rect_t              mrect;
	logic [DIM_W-1:0]   mw, mh;
	logic [2*DIM_W-1:0] mprod;
	logic [AREA_W-1:0]  area_mul;

	always_comb begin
		mrect = (state_q == J_B) ? b_q : rdata_q;
		mw = {1'b0, mrect.x2} - {1'b0, mrect.x1} + 13'd1;
		mh = {1'b0, mrect.y2} - {1'b0, mrect.y1} + 13'd1;
		mprod = mw * mh;
		area_mul = mprod[AREA_W-1:0];
	end

	// any unjoined entry left after slot i
	logic [REGION_SLOTS-1:0] more_vec;
	logic                    more_after;

	always_comb begin
		for (int k = 0; k < REGION_SLOTS; k++) begin
			more_vec[k] = (CW'(k) > i_q) && (CW'(k) < count_q) && !marks_q[k];
		end
		more_after = |more_vec;
	end

	logic emit_last;
	assign emit_last = (n_q == 6'(RESULT_CAP - 1)) || !more_after;

	// memory port control
	logic          wr_en;
	logic [IW-1:0] wr_addr, rd_addr;
	rect_t         wr_data;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = i_q[IW-1:0];
		wr_data = b_q;
		if (state_q == V_RD && i_q >= count_q) begin
			wr_en = 1'b1;
			if (count_q < SLOTS_C) begin
				wr_addr = count_q[IW-1:0];
				wr_data = c_q;
			end else begin
				wr_addr = '0;
				wr_data = screen_r;
			end
		end else if (state_q == J_CMP && merge_ok) begin
			wr_en = 1'b1;
		end
		rd_addr = (state_q == J_RD) ? j_q[IW-1:0] : i_q[IW-1:0];
	end

	// rectangle memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	// configuration registers, clamped to 1..4096
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_W_RST;
			scr_h_q <= SCREEN_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH: begin
					scr_w_q <= (cfg_data == '0) ? 13'd1 :
					           (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;
				end
				CFG_SCREEN_HEIGHT: begin
					scr_h_q <= (cfg_data == '0) ? 13'd1 :
					           (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;
				end
				default: ;
			endcase
		end
	end

	assign busy = (state_q != IDLE);

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			marks_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			merges_q     <= '0;
			result_valid <= 1'b0;
			status       <= ST_ADDED;
			region_index <= '0;
			out_x_left   <= '0;
			out_y_top    <= '0;
			out_x_right  <= '0;
			out_y_bottom <= '0;
			pixel_count  <= '0;
			merge_count  <= '0;
			entries_used <= '0;
			last         <= 1'b0;
		end else begin
			// drop the previous result after its cycle
			result_valid <= 1'b0;
			region_index <= '0;
			out_x_left   <= '0;
			out_y_top    <= '0;
			out_x_right  <= '0;
			out_y_bottom <= '0;
			pixel_count  <= '0;
			merge_count  <= '0;
			last         <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (start) begin
						i_q <= '0;
						unique case (kind)
							KIND_INVALIDATE: begin
								if (clip_empty) begin
									result_valid <= 1'b1;
									status       <= ST_OUTSIDE;
									entries_used <= 6'(count_q);
									last         <= 1'b1;
								end else begin
									c_q     <= clip_r;
									state_q <= V_RD;
								end
							end
							KIND_JOIN: begin
								merges_q <= '0;
								state_q  <= I_RD;
							end
							KIND_EMIT: begin
								n_q     <= '0;
								state_q <= E_SCAN;
							end
							KIND_CLEAR: begin
								count_q      <= '0;
								marks_q      <= '0;
								result_valid <= 1'b1;
								status       <= ST_CLEARED;
								entries_used <= '0;
								last         <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				// scan stored entries for one that covers the rectangle
				V_RD: begin
					if (i_q >= count_q) begin
						result_valid <= 1'b1;
						last         <= 1'b1;
						state_q      <= IDLE;
						if (count_q < SLOTS_C) begin
							marks_q[count_q[IW-1:0]] <= 1'b0;
							count_q      <= count_q + 1'b1;
							status       <= ST_ADDED;
							entries_used <= 6'(count_q + 1'b1);
						end else begin
							marks_q[0]   <= 1'b0;
							count_q      <= CW'(1);
							status       <= ST_OVERFLOW;
							entries_used <= 6'd1;
						end
					end else begin
						state_q <= V_CMP;
					end
				end
				V_CMP: begin
					if (inside_c) begin
						result_valid <= 1'b1;
						status       <= ST_COVERED;
						entries_used <= 6'(count_q);
						last         <= 1'b1;
						state_q      <= IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= V_RD;
					end
				end
				// outer entry of the join walk
				I_RD: begin
					if (i_q >= count_q) begin
						result_valid <= 1'b1;
						status       <= ST_JOINED;
						merge_count  <= merges_q;
						entries_used <= 6'(count_q);
						last         <= 1'b1;
						state_q      <= IDLE;
					end else if (marks_q[i_q[IW-1:0]]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= I_LD;
					end
				end
				I_LD: begin
					a_q      <= rdata_q;
					area_a_q <= area_mul;
					j_q      <= '0;
					state_q  <= J_RD;
				end
				// inner entry of the join walk
				J_RD: begin
					if (j_q >= count_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= I_RD;
					end else if (j_q == i_q || marks_q[j_q[IW-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= J_F;
					end
				end
				J_F: begin
					if (overlap_af) begin
						b_q      <= bbox;
						area_f_q <= area_mul;
						state_q  <= J_B;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= J_RD;
					end
				end
				J_B: begin
					area_b_q <= area_mul;
					state_q  <= J_CMP;
				end
				J_CMP: begin
					if (merge_ok) begin
						a_q      <= b_q;
						area_a_q <= area_b_q;
						marks_q[j_q[IW-1:0]] <= 1'b1;
						if (merges_q != 5'd31) begin
							merges_q <= merges_q + 5'd1;
						end
					end
					j_q     <= j_q + 1'b1;
					state_q <= J_RD;
				end
				// list unjoined entries
				E_SCAN: begin
					if (i_q >= count_q || n_q == 6'(RESULT_CAP)) begin
						if (n_q == '0) begin
							result_valid <= 1'b1;
							status       <= ST_NONE;
							entries_used <= 6'(count_q);
							last         <= 1'b1;
						end
						state_q <= IDLE;
					end else if (marks_q[i_q[IW-1:0]]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= E_LD;
					end
				end
				E_LD: begin
					result_valid <= 1'b1;
					status       <= ST_REGION;
					region_index <= 5'(i_q);
					out_x_left   <= rdata_q.x1;
					out_y_top    <= rdata_q.y1;
					out_x_right  <= rdata_q.x2;
					out_y_bottom <= rdata_q.y2;
					pixel_count  <= area_mul;
					entries_used <= 6'(count_q);
					last         <= emit_last;
					i_q          <= i_q + 1'b1;
					n_q          <= n_q + 6'd1;
					state_q      <= emit_last ? IDLE : E_SCAN;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`DRT_ASSERT(a_accept_acts, clk, arst_n, (start && !busy) |=> (busy || result_valid))
	`DRT_ASSERT(a_last_idles, clk, arst_n, (result_valid && last) |-> !busy)
	`DRT_ASSERT(a_single_last, clk, arst_n, (result_valid && status != ST_REGION) |-> last)
	`DRT_NEVER(a_count_range, clk, arst_n, count_q > SLOTS_C)
endmodule
`default_nettype wire

// ===== tb/drt_checker.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker checker
// Watches request, configuration and result transfers, predicts the results
// of each accepted request and compares them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module drt_checker
	import drt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          kind,
	input  logic signed [15:0]  x_left,
	input  logic signed [15:0]  y_top,
	input  logic signed [15:0]  x_right,
	input  logic signed [15:0]  y_bottom,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DIM_W-1:0]    cfg_data,
	input  logic                result_valid,
	input  logic [2:0]          status,
	input  logic [4:0]          region_index,
	input  logic [COORD_W-1:0]  out_x_left,
	input  logic [COORD_W-1:0]  out_y_top,
	input  logic [COORD_W-1:0]  out_x_right,
	input  logic [COORD_W-1:0]  out_y_bottom,
	input  logic [AREA_W-1:0]   pixel_count,
	input  logic [4:0]          merge_count,
	input  logic [5:0]          entries_used,
	input  logic                last,
	output int                  fail_count,
	output int                  pending
);
	localparam int SLOTS = SLOTS_DEFAULT;

	typedef struct {
		logic [2:0]         st;
		logic [4:0]         idx;
		logic [COORD_W-1:0] x1, y1, x2, y2;
		logic [AREA_W-1:0]  pix;
		logic [4:0]         merges;
		logic [5:0]         used;
		logic               fin;
	} region_result_t;

	typedef struct {
		int x1, y1, x2, y2;
	} box_t;

	region_result_t expected_results[$];
	box_t           boxes[SLOTS];
	bit             absorbed[SLOTS];
	int             box_count;
	int             scr_w, scr_h;

	assign pending = expected_results.size();

	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		if (v < 1) return 1;
		if (v > DIM_MAX) return DIM_MAX;
		return v;
	endfunction

	function automatic int area_of(box_t b);
		if (b.x1 > b.x2 || b.y1 > b.y2) return 0;
		return (b.x2 - b.x1 + 1) * (b.y2 - b.y1 + 1);
	endfunction

	function automatic region_result_t plain(logic [2:0] st, int merges);
		region_result_t r;
		r = '{st: st, idx: 0, x1: 0, y1: 0, x2: 0, y2: 0, pix: 0,
			merges: merges[4:0], used: box_count[5:0], fin: 1'b1};
		return r;
	endfunction

	// update the table for one request and queue what it produces
	task automatic predict_request(logic [1:0] k, int ax1, int ay1, int ax2, int ay2);
		box_t           c, a, f, bb;
		region_result_t r;
		int             merges, n;
		bit             covered;
		case (k)
			KIND_INVALIDATE: begin
				c.x1 = ax1 > 0 ? ax1 : 0;
				c.y1 = ay1 > 0 ? ay1 : 0;
				c.x2 = ax2 < scr_w - 1 ? ax2 : scr_w - 1;
				c.y2 = ay2 < scr_h - 1 ? ay2 : scr_h - 1;
				if (c.x1 > c.x2 || c.y1 > c.y2) begin
					expected_results.push_back(plain(ST_OUTSIDE, 0));
				end else begin
					covered = 0;
					for (int i = 0; i < box_count; i++)
						if (c.x1 >= boxes[i].x1 && c.y1 >= boxes[i].y1 &&
							c.x2 <= boxes[i].x2 && c.y2 <= boxes[i].y2)
							covered = 1;
					if (covered) begin
						expected_results.push_back(plain(ST_COVERED, 0));
					end else if (box_count < SLOTS) begin
						boxes[box_count] = c;
						absorbed[box_count] = 0;
						box_count++;
						expected_results.push_back(plain(ST_ADDED, 0));
					end else begin
						boxes[0] = '{0, 0, scr_w - 1, scr_h - 1};
						absorbed[0] = 0;
						box_count = 1;
						expected_results.push_back(plain(ST_OVERFLOW, 0));
					end
				end
			end
			KIND_JOIN: begin
				merges = 0;
				for (int i = 0; i < box_count; i++) begin
					if (absorbed[i]) continue;
					for (int j = 0; j < box_count; j++) begin
						if (absorbed[j] || i == j) continue;
						a = boxes[i];
						f = boxes[j];
						if (a.x1 > f.x2 || f.x1 > a.x2 || a.y1 > f.y2 || f.y1 > a.y2)
							continue;
						bb.x1 = a.x1 < f.x1 ? a.x1 : f.x1;
						bb.y1 = a.y1 < f.y1 ? a.y1 : f.y1;
						bb.x2 = a.x2 > f.x2 ? a.x2 : f.x2;
						bb.y2 = a.y2 > f.y2 ? a.y2 : f.y2;
						if (area_of(bb) < area_of(a) + area_of(f)) begin
							boxes[i] = bb;
							absorbed[j] = 1;
							if (merges < 31) merges++;
						end
					end
				end
				expected_results.push_back(plain(ST_JOINED, merges));
			end
			KIND_EMIT: begin
				n = 0;
				for (int i = 0; i < box_count && n < RESULT_CAP; i++) begin
					if (absorbed[i]) continue;
					r = plain(ST_REGION, 0);
					r.idx = i[4:0];
					r.x1 = boxes[i].x1[COORD_W-1:0];
					r.y1 = boxes[i].y1[COORD_W-1:0];
					r.x2 = boxes[i].x2[COORD_W-1:0];
					r.y2 = boxes[i].y2[COORD_W-1:0];
					r.pix = AREA_W'(area_of(boxes[i]));
					r.fin = 0;
					expected_results.push_back(r);
					n++;
				end
				if (n == 0)
					expected_results.push_back(plain(ST_NONE, 0));
				else
					expected_results[$].fin = 1;
			end
			default: begin
				box_count = 0;
				for (int i = 0; i < SLOTS; i++) absorbed[i] = 0;
				expected_results.push_back(plain(ST_CLEARED, 0));
			end
		endcase
	endtask

	task automatic report(string field, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field,
				exp_v, got_v);
			fail_count++;
		end
	endtask

	// compare each result transfer, then take in the request and config
	always @(posedge clk or negedge arst_n) begin
		region_result_t e;
		if (!arst_n) begin
			expected_results.delete();
			box_count = 0;
			for (int i = 0; i < SLOTS; i++) absorbed[i] = 0;
			scr_w = SCREEN_W_RST;
			scr_h = SCREEN_H_RST;
			fail_count = 0;
		end else begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d",
						$time, status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					report("status", e.st, status);
					report("region_index", e.idx, region_index);
					report("out_x_left", e.x1, out_x_left);
					report("out_y_top", e.y1, out_y_top);
					report("out_x_right", e.x2, out_x_right);
					report("out_y_bottom", e.y2, out_y_bottom);
					report("pixel_count", e.pix, pixel_count);
					report("merge_count", e.merges, merge_count);
					report("entries_used", e.used, entries_used);
					report("last", e.fin, last);
				end
			end
			if (start && !busy)
				predict_request(kind, x_left, y_top, x_right, y_bottom);
			if (cfg_we) begin
				if (cfg_index == CFG_SCREEN_WIDTH) scr_w = clamp_dim(cfg_data);
				else scr_h = clamp_dim(cfg_data);
			end
		end
	end
endmodule

// ===== tb/tb_dirty_rectangle_tracker.sv =====
// ----------------------------------------------------------------------------
// Dirty rectangle tracker testbench
// Directed requests at the field extremes, then random invalidate, join, emit
// and clear sequences over several screen sizes, some with random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_dirty_rectangle_tracker;
	import drt_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          kind;
	logic signed [15:0]  x_left, y_top, x_right, y_bottom;
	logic                cfg_we;
	logic                cfg_index;
	logic [DIM_W-1:0]    cfg_data;
	logic                result_valid;
	logic [2:0]          status;
	logic [4:0]          region_index;
	logic [COORD_W-1:0]  out_x_left, out_y_top, out_x_right, out_y_bottom;
	logic [AREA_W-1:0]   pixel_count;
	logic [4:0]          merge_count;
	logic [5:0]          entries_used;
	logic                last;
	int                  fail_count;
	int                  pending;
	int                  gap_pct;
	int                  scr_w, scr_h;
	int                  sent;

	dirty_rectangle_tracker u_dut (.*);

	drt_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// one request transfer, with a random gap in front
	task automatic send(logic [1:0] k, int x1 = 0, int y1 = 0, int x2 = 0, int y2 = 0);
		logic b;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start    <= 1'b1;
		kind     <= k;
		x_left   <= 16'(x1);
		y_top    <= 16'(y1);
		x_right  <= 16'(x2);
		y_bottom <= 16'(y2);
		forever begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
			if (!b) break;
		end
		sent++;
	endtask

	// drain all results, then write the screen size
	task automatic set_screen(int w, int h);
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= DIM_W'(w);
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= DIM_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w = w < 1 ? 1 : (w > 4096 ? 4096 : w);
		scr_h = h < 1 ? 1 : (h > 4096 ? 4096 : h);
	endtask

	// rectangle near the screen, mostly small, sometimes reversed
	task automatic send_rect();
		int x1, y1;
		x1 = int'($urandom_range(0, scr_w + 8)) - 4;
		y1 = int'($urandom_range(0, scr_h + 8)) - 4;
		send(KIND_INVALIDATE, x1, y1,
			x1 + int'($urandom_range(0, scr_w / 3 + 2)) - 1,
			y1 + int'($urandom_range(0, scr_h / 3 + 2)) - 1);
	endtask

	// well-formed sequences with random content, plus noise
	task automatic random_phase(int pct, int items);
		int target, n, off;
		gap_pct = pct;
		target = sent + items;
		while (sent < target) begin
			if ($urandom_range(9) == 0) begin
				send(2'($urandom_range(3)), $urandom_range(16'hFFFF) - 32768,
					$urandom_range(16'hFFFF) - 32768, $urandom_range(16'hFFFF) - 32768,
					$urandom_range(16'hFFFF) - 32768);
			end else begin
				if ($urandom_range(3) != 0) send(KIND_CLEAR);
				n = $urandom_range(3) == 0 ? $urandom_range(20, 36) : $urandom_range(1, 8);
				off = $urandom_range(3);
				for (int i = 0; i < n; i++) begin
					// disjoint pixels fill the table toward overflow
					if (n > 20 && scr_w > 80 && $urandom_range(3) != 0)
						send(KIND_INVALIDATE, 2 * i + off, 0, 2 * i + off, 0);
					else
						send_rect();
				end
				send(KIND_JOIN);
				if ($urandom_range(1)) send(KIND_JOIN);
				send(KIND_EMIT);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = KIND_INVALIDATE;
		x_left    = '0;
		y_top     = '0;
		x_right   = '0;
		y_bottom  = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SCREEN_WIDTH;
		cfg_data  = '0;
		gap_pct   = 0;
		sent      = 0;
		scr_w     = SCREEN_W_RST;
		scr_h     = SCREEN_H_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default screen
		send(KIND_EMIT);
		send(KIND_INVALIDATE, -32768, -32768, 32767, 32767);
		send(KIND_INVALIDATE, 10, 10, 20, 20);
		send(KIND_INVALIDATE, 30, 5, 20, 50);
		send(KIND_INVALIDATE, 480, 0, 500, 10);
		send(KIND_INVALIDATE, -1, -1, -1, -1);
		send(KIND_INVALIDATE, 0, -32768, 0, 0);
		send(KIND_EMIT);
		send(KIND_CLEAR);
		send(KIND_EMIT);
		send(KIND_INVALIDATE, 0, 0, 99, 99);
		send(KIND_INVALIDATE, 50, 50, 149, 149);
		send(KIND_INVALIDATE, 50, 0, 149, 99);
		send(KIND_JOIN);
		send(KIND_EMIT);
		send(KIND_JOIN);
		send(KIND_CLEAR);

		// directed: zero width acts as one column, oversize height as the max
		set_screen(0, 8191);
		send(KIND_INVALIDATE, 0, 0, 0, 4095);
		send(KIND_INVALIDATE, -5, 0, 3, 10);
		send(KIND_INVALIDATE, 1, 0, 5, 5);
		send(KIND_INVALIDATE, 32767, 32767, -32768, -32768);
		send(KIND_EMIT);
		send(KIND_CLEAR);

		set_screen(96, 64);
		random_phase(37, 120);
		set_screen(4096, 1);
		random_phase(56, 40);
		set_screen(1, 1);
		random_phase(0, 20);
		set_screen(200, 150);
		random_phase(0, 100);
		set_screen(4096, 4096);
		random_phase(0, 30);

		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("** dirty_rectangle_tracker: PASSED **");
		else
			$display("** dirty_rectangle_tracker: FAILED **");
		$finish;
	end

	initial begin
		#100ms;
		$display("** dirty_rectangle_tracker: FAILED **");
		$finish;
	end
endmodule
